// ===== rtl/key_press_event_detector_core_assert.svh =====
// Assertion macros shared by the key press event detector RTL
`ifndef KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH
`define KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KPED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KPED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kped_pkg.sv =====
// Package: types and constants of the key press event detector
`timescale 1ns / 1ps

package kped_pkg;

  localparam int TICK_BITS      = 32;
  localparam int TICK_IN_BITS   = 32;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(20);
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1000);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE_IDX   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS_IDX = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ticks;
    logic [CFG_BITS-1:0] long_press_ticks;
  } kped_cfg_t;

endpackage

// ===== rtl/kped_fsm.sv =====
// Press state machine: debounce, hold timer and short/long event decode
`timescale 1ns / 1ps

`include "key_press_event_detector_core_assert.svh"

module kped_fsm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic                                key_down,
  input  logic [kped_pkg::TICK_IN_BITS-1:0]   tick_now,
  input  kped_pkg::kped_cfg_t                 cfg,
  output kped_pkg::event_t                    key_event
);
  import kped_pkg::*;

  phase_t                 phase, phase_next;
  logic [TICK_BITS-1:0]   start_tick, start_tick_next;
  logic                   long_fired, long_fired_next;
  logic [TICK_BITS-1:0]   now;
  logic [TICK_BITS-1:0]   elapsed;
  logic                   debounce_done;
  logic                   long_done;

  assign now           = TICK_BITS'(tick_now);
  assign elapsed       = now - start_tick;   // wraps modulo 2^TICK_BITS
  assign debounce_done = elapsed >= TICK_BITS'(cfg.debounce_ticks);
  assign long_done     = elapsed >= TICK_BITS'(cfg.long_press_ticks);

  always_comb begin
    phase_next      = phase;
    start_tick_next = start_tick;
    long_fired_next = long_fired;
    key_event       = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (key_down) begin
          phase_next      = PH_DEBOUNCE;
          start_tick_next = now;
          long_fired_next = 1'b0;
        end
      end
      PH_DEBOUNCE: begin
        if (key_down) begin
          if (debounce_done) begin
            phase_next      = PH_PRESSED;
            start_tick_next = now;
            long_fired_next = 1'b0;
          end
        end else begin
          phase_next = PH_IDLE;   // bounce
        end
      end
      PH_PRESSED: begin
        if (key_down) begin
          if (long_done) begin
            key_event       = EV_LONG;
            long_fired_next = 1'b1;
            start_tick_next = now;  // restart for the repeat
          end
        end else begin
          if (!long_fired && !long_done) key_event = EV_SHORT;
          phase_next      = PH_IDLE;
          long_fired_next = 1'b0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      start_tick <= '0;
      long_fired <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      start_tick <= start_tick_next;
      long_fired <= long_fired_next;
    end
  end

  `KPED_ASSERT_NOW(a_short_on_release, clk, rst, accept && key_event == EV_SHORT, phase == PH_PRESSED && !key_down && !long_fired, "short event without release from pressed")
  `KPED_ASSERT_NEXT(a_idle_press, clk, rst, accept && phase == PH_IDLE && key_down, phase == PH_DEBOUNCE && start_tick == $past(now), "press from idle did not start debounce")
  `KPED_ASSERT_NEXT(a_long_marks, clk, rst, accept && key_event == EV_LONG, long_fired && phase == PH_PRESSED, "long event did not set the flag")

endmodule

// ===== rtl/key_press_event_detector_core.sv =====
// Top level: config registers, press state machine and output skid buffer
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------
//   sample   | key_valid / key_stall      | key_down, tick_now
//   event    | event_valid / event_stall  | key_event
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One sample per cycle unless key_stall; its event word is registered, shown the
// next cycle if not stalled. Update: wrapping subtract, compare, one state step.
// An output register plus one skid word keep input taking while the output stalls;
// key_stall rises only when both are full.
// rst is synchronous: state idle, buffers empty, registers back to 20 and 1000.
`timescale 1ns / 1ps

`include "key_press_event_detector_core_assert.svh"

module key_press_event_detector_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  key_valid,
  output logic                                  key_stall,
  input  logic                                  key_down,
  input  logic [kped_pkg::TICK_IN_BITS-1:0]     tick_now,
  output logic                                  event_valid,
  input  logic                                  event_stall,
  output logic [1:0]                            key_event,
  input  logic                                  cfg_we,
  input  logic [kped_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [kped_pkg::CFG_BITS-1:0]         cfg_data
);
  import kped_pkg::*;

  kped_cfg_t cfg;
  logic      accept;
  logic      out_free;
  event_t    new_event;
  event_t    out_event;
  event_t    skid_event;
  logic      skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_IDX:   cfg.debounce_ticks   <= cfg_data;
        CFG_LONG_PRESS_IDX: cfg.long_press_ticks <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign key_stall = skid_valid;
  assign accept    = key_valid && !key_stall;
  assign out_free  = !event_valid || !event_stall;

  kped_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .key_down  (key_down),
    .tick_now  (tick_now),
    .cfg       (cfg),
    .key_event (new_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        event_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end else begin
        event_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;   // output held: park the word
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_event <= skid_valid ? skid_event : new_event;
    end
    if (!out_free && accept) begin
      skid_event <= new_event;
    end
  end

  assign key_event = out_event;

  `KPED_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, event_valid, "skid word without output word")
  `KPED_ASSERT_NEXT(a_stall_holds_word, clk, rst, event_valid && event_stall, event_valid && key_event == $past(key_event), "stalled event word changed")
  `KPED_ASSERT_NEXT(a_accept_shows, clk, rst, accept && out_free && !skid_valid, event_valid, "accepted sample produced no word")

endmodule

// ===== tb/tb_key_press_event_detector_core.sv =====
// Testbench: key press event detector core, random presses checked against a local predictor
`timescale 1ns / 1ps

module tb_key_press_event_detector_core;
  import kped_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic                    down;
    logic [TICK_IN_BITS-1:0] tick;
    int unsigned             gap;
  } key_sample_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      key_valid = 1'b0;
  logic                      key_stall;
  logic                      key_down = 1'b0;
  logic [TICK_IN_BITS-1:0]   tick_now = '0;
  logic                      event_valid;
  logic                      event_stall = 1'b0;
  logic [1:0]                key_event;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_DEBOUNCE_IDX;
  logic [CFG_BITS-1:0]       cfg_data = '0;

  key_press_event_detector_core dut (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_down   (key_down),
    .tick_now   (tick_now),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .key_event  (key_event),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state and its copy of the registers
  phase_t             key_phase;
  logic [TICK_BITS-1:0] hold_start;
  logic               long_seen;
  logic [CFG_BITS-1:0] debounce_cfg;
  logic [CFG_BITS-1:0] long_cfg;

  key_sample_t pending_samples[$];
  event_t      expected_events[$];

  bit          word_taken;
  int unsigned gap_left;
  int unsigned sink_hold;
  bit          sink_calm;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  int unsigned mismatches;

  // stimulus side: tick clock and the settings the press shapes are built around
  logic [TICK_IN_BITS-1:0] sample_clock;
  int unsigned             stim_debounce;
  int unsigned             stim_long;
  int unsigned             queued;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic event_t press_event_for(logic down, logic [TICK_BITS-1:0] now);
    logic [TICK_BITS-1:0] held;
    event_t               ev;
    ev   = EV_NONE;
    held = now - hold_start;
    case (key_phase)
      PH_IDLE: begin
        if (down) begin
          key_phase  = PH_DEBOUNCE;
          hold_start = now;
          long_seen  = 1'b0;
        end
      end
      PH_DEBOUNCE: begin
        if (!down) begin
          key_phase = PH_IDLE;  // bounce
        end else if (held >= TICK_BITS'(debounce_cfg)) begin
          key_phase  = PH_PRESSED;
          hold_start = now;
          long_seen  = 1'b0;
        end
      end
      PH_PRESSED: begin
        if (down) begin
          if (held >= TICK_BITS'(long_cfg)) begin
            ev         = EV_LONG;
            long_seen  = 1'b1;
            hold_start = now;
          end
        end else begin
          if (!long_seen && held < TICK_BITS'(long_cfg)) ev = EV_SHORT;
          key_phase = PH_IDLE;
          long_seen = 1'b0;
        end
      end
      default: key_phase = PH_IDLE;
    endcase
    return ev;
  endfunction

  // sample and result handshakes, register writes, quiet-cycle count
  always @(posedge clk) begin
    if (rst) begin
      key_phase    = PH_IDLE;
      hold_start   = '0;
      long_seen    = 1'b0;
      debounce_cfg = DEBOUNCE_RESET;
      long_cfg     = LONG_PRESS_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE_IDX:   debounce_cfg = cfg_data;
          CFG_LONG_PRESS_IDX: long_cfg     = cfg_data;
          default: ;
        endcase
      end
      if (key_valid && !key_stall) begin
        expected_events.push_back(press_event_for(key_down, tick_now));
        word_taken   = 1'b1;
        quiet_cycles = 0;
      end
      if (event_valid && !event_stall) begin
        quiet_cycles = 0;
        if (expected_events.size() == 0) begin
          $error("key_event word %0d with none expected", key_event);
          mismatches++;
        end else begin
          event_t want;
          want = expected_events.pop_front();
          if (key_event !== want) begin
            $error("key_event expected %0d actual %0d", want, key_event);
            mismatches++;
          end
        end
        results_seen++;
        if (results_seen % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
        sink_hold = sink_calm ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // sample driver: a word is held until taken, then the next one after its gap
  always @(negedge clk) begin
    if (!key_valid || word_taken) begin
      word_taken = 1'b0;
      if (pending_samples.size() != 0 && gap_left >= pending_samples[0].gap) begin
        key_sample_t cur;
        cur = pending_samples.pop_front();
        key_valid <= 1'b1;
        key_down  <= cur.down;
        tick_now  <= cur.tick;
        gap_left  = 0;
      end else begin
        key_valid <= 1'b0;
        if (pending_samples.size() != 0) gap_left++;
      end
    end
  end

  // event sink stall
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      event_stall <= 1'b1;
      sink_hold--;
    end else begin
      event_stall <= 1'b0;
    end
  end

  task automatic push_word(logic down, logic [TICK_IN_BITS-1:0] tick, bit calm);
    key_sample_t s;
    s.down = down;
    s.tick = tick;
    s.gap  = calm ? 0 : $urandom_range(0, 6);
    pending_samples.push_back(s);
    queued++;
  endtask

  // tick advance aimed at the debounce and long thresholds, with the odd huge jump
  function automatic int unsigned pick_step();
    int unsigned t;
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(0, 3);
      2: begin
        t = stim_debounce + $urandom_range(0, 2);
        return (t == 0) ? 0 : t - 1;
      end
      3: begin
        t = stim_long + $urandom_range(0, 2);
        return (t == 0) ? 0 : t - 1;
      end
      4: return $urandom_range(0, stim_long);
      5: return $urandom_range(0, stim_debounce);
      6: return $urandom_range(0, stim_debounce + stim_long);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_sample(logic down, int unsigned step, bit calm);
    sample_clock = sample_clock + step;
    push_word(down, sample_clock, calm);
  endtask

  task automatic queue_press();
    bit calm;
    calm = ($urandom_range(0, 4) == 0);
    repeat ($urandom_range(0, 2)) add_sample(1'b0, pick_step(), calm);
    if ($urandom_range(0, 3) == 0) begin
      add_sample(1'b1, pick_step(), calm);
      add_sample(1'b0, $urandom_range(0, 3), calm);
    end
    repeat ($urandom_range(1, 8)) add_sample(1'b1, pick_step(), calm);
    add_sample(1'b0, pick_step(), calm);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (!(pending_samples.size() == 0 && !key_valid && expected_events.size() == 0));
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic run_phase(logic [CFG_BITS-1:0] deb, logic [CFG_BITS-1:0] lp,
                           int unsigned budget);
    drain();
    write_reg(CFG_DEBOUNCE_IDX, deb);
    write_reg(CFG_LONG_PRESS_IDX, lp);
    stim_debounce = deb;
    stim_long     = lp;
    queued        = 0;
    while (queued < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any level at any tick
        sample_clock = $urandom;
        add_sample(1'($urandom_range(0, 1)), 0, 1'b0);
      end else begin
        queue_press();
      end
    end
  endtask

  initial begin
    sink_calm = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: reset settings 20 / 1000, tick wrap in the debounce window
    push_word(1'b0, 32'h0000_0000, 1'b0);
    push_word(1'b1, 32'hFFFF_FFF0, 1'b0);
    push_word(1'b0, 32'hFFFF_FFF5, 1'b0);   // release while debouncing
    push_word(1'b1, 32'hFFFF_FFF8, 1'b0);
    push_word(1'b1, 32'hFFFF_FFFF, 1'b0);
    push_word(1'b1, 32'h0000_000B, 1'b0);   // one short of debounce across the wrap
    push_word(1'b1, 32'h0000_000C, 1'b0);   // confirmed
    push_word(1'b1, 32'h0000_03F3, 1'b0);
    push_word(1'b0, 32'h0000_03F4, 1'b0);   // held exactly the long period: no event
    push_word(1'b1, 32'd100, 1'b0);
    push_word(1'b1, 32'd120, 1'b0);
    push_word(1'b0, 32'd1119, 1'b0);        // short press
    push_word(1'b1, 32'd2000, 1'b0);
    push_word(1'b1, 32'd2020, 1'b0);
    push_word(1'b1, 32'd3020, 1'b0);        // long
    push_word(1'b1, 32'd3500, 1'b0);
    push_word(1'b0, 32'd3600, 1'b0);        // release after long: nothing
    push_word(1'b1, 32'd4000, 1'b0);
    push_word(1'b1, 32'd4020, 1'b0);
    push_word(1'b1, 32'd5020, 1'b0);
    push_word(1'b1, 32'd6020, 1'b0);        // long repeats
    push_word(1'b0, 32'd6021, 1'b0);
    push_word(1'b0, 32'hFFFF_FFFF, 1'b0);

    sample_clock = 32'hFFFF_0000;
    run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 110);
    run_phase(16'd0, 16'd1, 105);
    run_phase(16'hFFFF, 16'hFFFF, 105);
    run_phase(16'd0, 16'd0, 105);           // every held sample in the pressed phase fires long
    run_phase(16'd3, 16'd50, 105);
    run_phase(CFG_BITS'($urandom_range(0, 16'hFFFF)),
              CFG_BITS'($urandom_range(1, 16'hFFFF)), 105);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog on handshake progress
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule
